@@ hw/rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int NUM_SW         = 4;
    localparam int CFG_W          = 16;
    localparam int NUM_CFG        = 8;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int CMD_W          = 2;
    localparam int CLASS_W        = 2;
    localparam int COUNT_WIDTH_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEEP   = 2'd2;

    // Press class codes as reported
    localparam logic [CLASS_W-1:0] CLS_NONE  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SHORT = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_MID   = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_LONG  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_SHORT_MID   = 3'd0;
    localparam logic [2:0] REG_MID_LONG    = 3'd1;
    localparam logic [2:0] REG_MID_PERIOD  = 3'd2;
    localparam logic [2:0] REG_LONG_PERIOD = 3'd3;
    localparam logic [2:0] REG_BEEP_DUR    = 3'd4;
    localparam logic [2:0] REG_LOW_TONE    = 3'd5;
    localparam logic [2:0] REG_MID_TONE    = 3'd6;
    localparam logic [2:0] REG_HIGH_TONE   = 3'd7;

    // Pending threshold beep per switch
    typedef enum logic [3:0] {
        STG_NONE = 4'b0001,
        STG_LOW  = 4'b0010,
        STG_MID  = 4'b0100,
        STG_HIGH = 4'b1000
    } stage_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_mid_limit;
        logic [CFG_W-1:0] mid_long_limit;
        logic [CFG_W-1:0] mid_repeat_period;
        logic [CFG_W-1:0] long_repeat_period;
        logic [CFG_W-1:0] beep_duration;
        logic [CFG_W-1:0] low_tone;
        logic [CFG_W-1:0] mid_tone;
        logic [CFG_W-1:0] high_tone;
    } cfg_t;

    // Per-lane state after the current beat, plus the lane's buzzer request
    typedef struct packed {
        logic               pressed;
        logic               buz_on;
        logic [CFG_W-1:0]   tone;
        logic [CLASS_W-1:0] press_class;
        logic               mid_reached;
        logic               long_reached;
        logic               mid_repeat;
        logic               long_repeat;
        logic               beep_active;
    } lane_stat_t;

    typedef struct packed {
        logic             on;
        logic [CFG_W-1:0] prescale;
    } pwm_t;

endpackage

@@ hw/rtl/bpc_item_if.sv @@
`timescale 1ns / 1ps

interface bpc_item_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::CMD_W-1:0]   cmd;
    logic [bpc_pkg::NUM_SW-1:0]  pin_levels;
    logic                        buzzer_enable;

    modport source (output valid, cmd, pin_levels, buzzer_enable, input ready);
    modport sink (input valid, cmd, pin_levels, buzzer_enable, output ready);
endinterface

@@ hw/rtl/bpc_result_if.sv @@
`timescale 1ns / 1ps

interface bpc_result_if;
    logic                         valid;
    logic                         ready;
    logic [bpc_pkg::CLASS_W-1:0]  class_sw0;
    logic [bpc_pkg::CLASS_W-1:0]  class_sw1;
    logic [bpc_pkg::CLASS_W-1:0]  class_sw2;
    logic [bpc_pkg::CLASS_W-1:0]  class_sw3;
    logic [bpc_pkg::NUM_SW-1:0]   mid_reached_mask;
    logic [bpc_pkg::NUM_SW-1:0]   long_reached_mask;
    logic [bpc_pkg::NUM_SW-1:0]   mid_repeat_mask;
    logic [bpc_pkg::NUM_SW-1:0]   long_repeat_mask;
    logic [bpc_pkg::NUM_SW-1:0]   beep_active_mask;
    logic                         buzzer_on;
    logic [bpc_pkg::CFG_W-1:0]    buzzer_prescale;

    modport source (output valid, class_sw0, class_sw1, class_sw2, class_sw3,
                    mid_reached_mask, long_reached_mask, mid_repeat_mask,
                    long_repeat_mask, beep_active_mask, buzzer_on, buzzer_prescale,
                    input ready);
    modport sink (input valid, class_sw0, class_sw1, class_sw2, class_sw3,
                  mid_reached_mask, long_reached_mask, mid_repeat_mask,
                  long_repeat_mask, beep_active_mask, buzzer_on, buzzer_prescale,
                  output ready);
endinterface

@@ hw/rtl/button_press_classifier_core.sv @@
`timescale 1ns / 1ps

// Button press classifier for four push buttons with threshold beeps.
//
// item channel (sink): one beat per event. cmd selects a pin sample with
// evaluation, a press-timer tick or a beep-timer tick; pin_levels and
// buzzer_enable are used by the sample only. Code 3 changes nothing.
// result channel (source): exactly one beat per item, giving the class of
// each switch, the per-switch flag masks and the buzzer state after the event.
// Timing: the result is registered and is valid in the cycle after the item
// beat. Throughput: one item per cycle while the receiver takes results; four
// lanes update all switches in the same cycle and a merging stage picks the
// buzzer state from the lanes, so one compare-and-count level sets the rate.
// Stall: a single result register parts the channels. While a result waits
// for the receiver, item.ready stays high only if that result is taken in the
// same cycle; otherwise the item side holds until the receiver drains.
// Reset (rst_n, async low): all switch state, the buzzer state and the result
// valid flag clear; configuration returns to its defaults. No clearing pass:
// items are accepted from the first cycle after reset.
// Configuration: APB-style, 16-bit registers at byte offsets 4*i; pready is
// tied high; write only while the block is idle.

module button_press_classifier_core #(
    parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bpc_item_if.sink                      item,
    bpc_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bpc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    bpc_pkg::cfg_t        cfg_reg;
    logic [2:0]           reg_idx;
    logic                 cfg_wr;
    logic [bpc_pkg::CFG_W-1:0] cfg_rd;

    logic                 step;
    bpc_pkg::lane_stat_t  stat [bpc_pkg::NUM_SW];
    bpc_pkg::pwm_t        pwm_next;

    logic                 out_valid_reg;
    bpc_pkg::lane_stat_t  out_stat_reg [bpc_pkg::NUM_SW];
    bpc_pkg::pwm_t        out_pwm_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_mid_limit    <= 16'd50;
            cfg_reg.mid_long_limit     <= 16'd200;
            cfg_reg.mid_repeat_period  <= 16'd20;
            cfg_reg.long_repeat_period <= 16'd5;
            cfg_reg.beep_duration      <= 16'd10;
            cfg_reg.low_tone           <= 16'd400;
            cfg_reg.mid_tone           <= 16'd300;
            cfg_reg.high_tone          <= 16'd200;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                bpc_pkg::REG_SHORT_MID:   cfg_reg.short_mid_limit    <= pwdata[15:0];
                bpc_pkg::REG_MID_LONG:    cfg_reg.mid_long_limit     <= pwdata[15:0];
                bpc_pkg::REG_MID_PERIOD:  cfg_reg.mid_repeat_period  <= pwdata[15:0];
                bpc_pkg::REG_LONG_PERIOD: cfg_reg.long_repeat_period <= pwdata[15:0];
                bpc_pkg::REG_BEEP_DUR:    cfg_reg.beep_duration      <= pwdata[15:0];
                bpc_pkg::REG_LOW_TONE:    cfg_reg.low_tone           <= pwdata[15:0];
                bpc_pkg::REG_MID_TONE:    cfg_reg.mid_tone           <= pwdata[15:0];
                bpc_pkg::REG_HIGH_TONE:   cfg_reg.high_tone          <= pwdata[15:0];
                default:                  cfg_reg.high_tone          <= cfg_reg.high_tone;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bpc_pkg::REG_SHORT_MID:   cfg_rd = cfg_reg.short_mid_limit;
            bpc_pkg::REG_MID_LONG:    cfg_rd = cfg_reg.mid_long_limit;
            bpc_pkg::REG_MID_PERIOD:  cfg_rd = cfg_reg.mid_repeat_period;
            bpc_pkg::REG_LONG_PERIOD: cfg_rd = cfg_reg.long_repeat_period;
            bpc_pkg::REG_BEEP_DUR:    cfg_rd = cfg_reg.beep_duration;
            bpc_pkg::REG_LOW_TONE:    cfg_rd = cfg_reg.low_tone;
            bpc_pkg::REG_MID_TONE:    cfg_rd = cfg_reg.mid_tone;
            bpc_pkg::REG_HIGH_TONE:   cfg_rd = cfg_reg.high_tone;
            default:                  cfg_rd = '0;
        endcase
    end

    assign prdata = bpc_pkg::PDATA_W'(cfg_rd);

    // ---------------- handshake ----------------
    // take a new beat whenever the result register is empty or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign step       = item.valid && item.ready;

    // ---------------- switch lanes ----------------
    for (genvar g = 0; g < bpc_pkg::NUM_SW; g++)
    begin : g_lane
        bpc_lane #(
            .CNT_W (COUNT_WIDTH)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .step   (step),
            .cmd    (item.cmd),
            .pin    (item.pin_levels[g]),
            .enable (item.buzzer_enable),
            .cfg    (cfg_reg),
            .stat   (stat[g])
        );
    end

    // ---------------- buzzer merge ----------------
    bpc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (step && (item.cmd == bpc_pkg::CMD_SAMPLE)),
        .stat     (stat),
        .pwm_next (pwm_next)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // capture the state after the beat; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_stat_reg <= stat;
            out_pwm_reg  <= pwm_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.class_sw0       = out_stat_reg[0].press_class;
    assign result.class_sw1       = out_stat_reg[1].press_class;
    assign result.class_sw2       = out_stat_reg[2].press_class;
    assign result.class_sw3       = out_stat_reg[3].press_class;
    assign result.buzzer_on       = out_pwm_reg.on;
    assign result.buzzer_prescale = out_pwm_reg.prescale;

    always_comb
    begin
        for (int i = 0; i < bpc_pkg::NUM_SW; i++)
        begin
            result.mid_reached_mask[i]  = out_stat_reg[i].mid_reached;
            result.long_reached_mask[i] = out_stat_reg[i].long_reached;
            result.mid_repeat_mask[i]   = out_stat_reg[i].mid_repeat;
            result.long_repeat_mask[i]  = out_stat_reg[i].long_repeat;
            result.beep_active_mask[i]  = out_stat_reg[i].beep_active;
        end
    end

`ifndef SYNTHESIS
    // every accepted beat shows up as a result in the next cycle
    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted beat did not produce a result");

    // input is held off only by a result that the receiver refuses
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (out_valid_reg && !result.ready))
        else $error("input stalled without output backpressure");

    // a result that was not taken and not replaced stays put
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_pwm_reg)))
        else $error("pending result dropped or changed");
`endif

endmodule

@@ hw/rtl/bpc_lane.sv @@
`timescale 1ns / 1ps

module bpc_lane #(
    parameter int CNT_W = bpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [bpc_pkg::CMD_W-1:0]  cmd,
    input  logic                       pin,
    input  logic                       enable,
    input  bpc_pkg::cfg_t              cfg,
    output bpc_pkg::lane_stat_t        stat
);

    localparam int CMP_W = (CNT_W > bpc_pkg::CFG_W) ? CNT_W : bpc_pkg::CFG_W;

    logic                          pressed_reg, pressed_next;
    logic [bpc_pkg::CLASS_W-1:0]   class_reg, class_next;
    bpc_pkg::stage_t               stage_reg, stage_next, stage_s;
    logic [CNT_W-1:0]              hold_reg, hold_next;
    logic [CNT_W-1:0]              mid_cnt_reg, mid_cnt_next;
    logic [CNT_W-1:0]              long_cnt_reg, long_cnt_next;
    logic                          mid_reached_reg, mid_reached_next;
    logic                          long_reached_reg, long_reached_next;
    logic                          mid_repeat_reg, mid_repeat_next;
    logic                          long_repeat_reg, long_repeat_next;
    logic                          beep_active_reg, beep_active_next;
    logic [CNT_W-1:0]              beep_ticks_reg, beep_ticks_next;
    logic [bpc_pkg::CFG_W-1:0]     beep_tone_reg, beep_tone_next;

    logic             hold_le_short, hold_le_long;
    logic [CNT_W-1:0] mid_inc, long_inc, beep_inc;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    assign hold_le_short = CMP_W'(hold_reg) <= CMP_W'(cfg.short_mid_limit);
    assign hold_le_long  = CMP_W'(hold_reg) <= CMP_W'(cfg.mid_long_limit);
    assign mid_inc  = sat_inc(mid_cnt_reg);
    assign long_inc = sat_inc(long_cnt_reg);
    assign beep_inc = sat_inc(beep_ticks_reg);

    always_comb
    begin
        pressed_next      = pressed_reg;
        class_next        = class_reg;
        stage_next        = stage_reg;
        hold_next         = hold_reg;
        mid_cnt_next      = mid_cnt_reg;
        long_cnt_next     = long_cnt_reg;
        mid_reached_next  = mid_reached_reg;
        long_reached_next = long_reached_reg;
        mid_repeat_next   = mid_repeat_reg;
        long_repeat_next  = long_repeat_reg;
        beep_active_next  = beep_active_reg;
        beep_ticks_next   = beep_ticks_reg;
        beep_tone_next    = beep_tone_reg;
        // restart the tone sequence on the press edge only
        stage_s           = pressed_reg ? stage_reg : bpc_pkg::STG_LOW;

        unique case (cmd)
            bpc_pkg::CMD_SAMPLE:
            begin
                pressed_next = pin;
                if (!pin)
                begin
                    class_next        = bpc_pkg::CLS_NONE;
                    stage_next        = bpc_pkg::STG_NONE;
                    mid_reached_next  = 1'b0;
                    long_reached_next = 1'b0;
                    mid_repeat_next   = 1'b0;
                    long_repeat_next  = 1'b0;
                    hold_next         = '0;
                    beep_ticks_next   = '0;
                end
                else
                begin
                    stage_next = stage_s;
                    if (hold_le_short)
                    begin
                        class_next = bpc_pkg::CLS_SHORT;
                        if (stage_s == bpc_pkg::STG_LOW)
                        begin
                            beep_active_next = 1'b1;
                            beep_tone_next   = cfg.low_tone;
                            stage_next       = bpc_pkg::STG_MID;
                        end
                    end
                    else if (hold_le_long)
                    begin
                        class_next = bpc_pkg::CLS_MID;
                        if (stage_s == bpc_pkg::STG_MID)
                        begin
                            beep_active_next = 1'b1;
                            beep_tone_next   = cfg.mid_tone;
                            stage_next       = bpc_pkg::STG_HIGH;
                            mid_reached_next = 1'b1;
                        end
                    end
                    else
                    begin
                        class_next = bpc_pkg::CLS_LONG;
                        if (stage_s == bpc_pkg::STG_HIGH)
                        begin
                            beep_active_next  = 1'b1;
                            beep_tone_next    = cfg.high_tone;
                            stage_next        = bpc_pkg::STG_NONE;
                            long_reached_next = 1'b1;
                        end
                    end
                end
            end
            bpc_pkg::CMD_PRESS:
            begin
                if (hold_le_long)
                begin
                    hold_next = sat_inc(hold_reg);
                end
                if (class_reg == bpc_pkg::CLS_MID)
                begin
                    if (CMP_W'(mid_inc) > CMP_W'(cfg.mid_repeat_period))
                    begin
                        mid_cnt_next    = '0;
                        mid_repeat_next = 1'b1;
                    end
                    else
                    begin
                        mid_cnt_next = mid_inc;
                    end
                end
                else if (class_reg == bpc_pkg::CLS_LONG)
                begin
                    if (CMP_W'(long_inc) > CMP_W'(cfg.long_repeat_period))
                    begin
                        long_cnt_next    = '0;
                        long_repeat_next = 1'b1;
                    end
                    else
                    begin
                        long_cnt_next = long_inc;
                    end
                end
            end
            bpc_pkg::CMD_BEEP:
            begin
                if (beep_active_reg)
                begin
                    if (CMP_W'(beep_inc) > CMP_W'(cfg.beep_duration))
                    begin
                        beep_active_next = 1'b0;
                        beep_ticks_next  = '0;
                    end
                    else
                    begin
                        beep_ticks_next = beep_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg      <= 1'b0;
            class_reg        <= bpc_pkg::CLS_NONE;
            stage_reg        <= bpc_pkg::STG_NONE;
            hold_reg         <= '0;
            mid_cnt_reg      <= '0;
            long_cnt_reg     <= '0;
            mid_reached_reg  <= 1'b0;
            long_reached_reg <= 1'b0;
            mid_repeat_reg   <= 1'b0;
            long_repeat_reg  <= 1'b0;
            beep_active_reg  <= 1'b0;
            beep_ticks_reg   <= '0;
            beep_tone_reg    <= '0;
        end
        else if (step)
        begin
            pressed_reg      <= pressed_next;
            class_reg        <= class_next;
            stage_reg        <= stage_next;
            hold_reg         <= hold_next;
            mid_cnt_reg      <= mid_cnt_next;
            long_cnt_reg     <= long_cnt_next;
            mid_reached_reg  <= mid_reached_next;
            long_reached_reg <= long_reached_next;
            mid_repeat_reg   <= mid_repeat_next;
            long_repeat_reg  <= long_repeat_next;
            beep_active_reg  <= beep_active_next;
            beep_ticks_reg   <= beep_ticks_next;
            beep_tone_reg    <= beep_tone_next;
        end
    end

    always_comb
    begin
        stat.pressed      = pressed_next;
        stat.buz_on       = enable && beep_active_next;
        stat.tone         = beep_tone_next;
        stat.press_class  = class_next;
        stat.mid_reached  = mid_reached_next;
        stat.long_reached = long_reached_next;
        stat.mid_repeat   = mid_repeat_next;
        stat.long_repeat  = long_repeat_next;
        stat.beep_active  = beep_active_next;
    end

`ifndef SYNTHESIS
    // the long beep can only follow the mid beep of the same press
    a_long_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
        long_reached_reg |-> mid_reached_reg)
        else $error("long threshold reached without mid threshold");

    // a switch with no class carries no threshold or repeat flags
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (class_reg == bpc_pkg::CLS_NONE) |->
            !(mid_reached_reg || long_reached_reg || mid_repeat_reg || long_repeat_reg))
        else $error("flags set on a switch with no press class");

    // a released switch has no pending tone
    a_released_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pressed_reg |-> (stage_reg == bpc_pkg::STG_NONE))
        else $error("tone pending on a released switch");
`endif

endmodule

@@ hw/rtl/bpc_merge.sv @@
`timescale 1ns / 1ps

module bpc_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample,
    input  bpc_pkg::lane_stat_t  stat [bpc_pkg::NUM_SW],
    output bpc_pkg::pwm_t        pwm_next
);

    bpc_pkg::pwm_t pwm_reg;

    // walk lanes upward: the highest pressed switch sets the run state,
    // the prescale follows the highest pressed switch that sounds
    always_comb
    begin
        pwm_next = pwm_reg;
        if (sample)
        begin
            for (int i = 0; i < bpc_pkg::NUM_SW; i++)
            begin
                if (stat[i].pressed)
                begin
                    pwm_next.on = stat[i].buz_on;
                    if (stat[i].buz_on)
                    begin
                        pwm_next.prescale = stat[i].tone;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_reg <= '0;
        end
        else
        begin
            pwm_reg <= pwm_next;
        end
    end

endmodule
